FILE: rtl/bba_pkg.sv
package bba_pkg;

  // Default geometry of the arena
  localparam int unsigned ArenaBytesDef  = 4096;
  localparam int unsigned LevelCountDef  = 8;
  localparam int unsigned MinShiftDef    = 5;
  localparam int unsigned HeaderBytesDef = 4;

  // Fixed field widths
  localparam int unsigned LVL_W       = 4;
  localparam int unsigned SIZE_W      = 13;
  localparam int unsigned OFF_W       = 12;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 16;

  // Status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;

  // Request kinds
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // One slot header: level of the block that begins there and its taken flag
  typedef struct packed {
    logic             taken;
    logic [LVL_W-1:0] level;
  } hdr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WALK,
    ST_SPLIT,
    ST_FREE_HDR,
    ST_FREE_MERGE,
    ST_RESP
  } state_e;

endpackage

FILE: rtl/bba_hdr_ram.sv
module bba_hdr_ram
  import bba_pkg::*;
#(
  parameter int unsigned SLOT_COUNT  = ArenaBytesDef >> MinShiftDef,
  parameter int unsigned IDX_W       = $clog2(ArenaBytesDef >> MinShiftDef),
  parameter int unsigned LEVEL_COUNT = LevelCountDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output hdr_t             rdata_o,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  hdr_t             wdata_i,
  output logic             init_done_o
);

  localparam hdr_t TopHdr = '{taken: 1'b0, level: LVL_W'(LEVEL_COUNT - 1)};

  hdr_t             hdr_mem [SLOT_COUNT];
  hdr_t             rdata_q;
  logic [IDX_W-1:0] clr_idx_q;
  logic             clr_busy_q;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  hdr_t             wr_data;

  // Select between the clearing sweep and the controller's write port
  always_comb begin
    if (clr_busy_q) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx_q;
      wr_data = (clr_idx_q == '0) ? TopHdr : '0;
    end else begin
      wr_en   = we_i;
      wr_addr = waddr_i;
      wr_data = wdata_i;
    end
  end

  // Sweep every slot once after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_idx_q == IDX_W'(SLOT_COUNT - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_idx_q <= clr_idx_q + 1'b1;
      end
    end
  end

  // Single write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hdr_mem[wr_addr] <= wr_data;
    end
    if (re_i) begin
      rdata_q <= hdr_mem[raddr_i];
    end
  end

  assign rdata_o     = rdata_q;
  assign init_done_o = ~clr_busy_q;

endmodule

FILE: rtl/bba_ctrl.sv
module bba_ctrl
  import bba_pkg::*;
#(
  parameter int unsigned ARENA_BYTES  = ArenaBytesDef,
  parameter int unsigned LEVEL_COUNT  = LevelCountDef,
  parameter int unsigned MIN_SHIFT    = MinShiftDef,
  parameter int unsigned HEADER_BYTES = HeaderBytesDef,
  parameter int unsigned SLOT_COUNT   = ArenaBytesDef >> MinShiftDef,
  parameter int unsigned IDX_W        = $clog2(ArenaBytesDef >> MinShiftDef)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              init_done_i,
  // request side
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic              mode_i,
  input  logic [SIZE_W-1:0] request_size_i,
  input  logic [OFF_W-1:0]  free_offset_i,
  // result side
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output logic [OFF_W-1:0]  result_offset_o,
  output logic              status_o,
  // header memory
  output logic              mem_re_o,
  output logic [IDX_W-1:0]  mem_raddr_o,
  input  hdr_t              mem_rdata_i,
  output logic              mem_we_o,
  output logic [IDX_W-1:0]  mem_waddr_o,
  output hdr_t              mem_wdata_o
);

  localparam int unsigned SUM_W   = ((IDX_W > 16) ? IDX_W : 16) + 1;
  localparam int unsigned TOTAL_W = SIZE_W + 1;
  localparam int unsigned LIM_W   = MIN_SHIFT + LEVEL_COUNT + 1;
  localparam int unsigned CMP_W   = (LIM_W > TOTAL_W) ? LIM_W : TOTAL_W;
  localparam int unsigned ACMP_W0 = $clog2(ARENA_BYTES) + 1;
  localparam int unsigned ACMP_W  = (ACMP_W0 > OFF_W) ? ACMP_W0 : OFF_W;
  localparam int unsigned POS_W   = SUM_W + MIN_SHIFT + 1;

  localparam logic [LVL_W-1:0] TopLevel  = LVL_W'(LEVEL_COUNT - 1);
  localparam logic [LVL_W-1:0] FailLevel = LVL_W'(LEVEL_COUNT);

  state_e             state_q, state_d;
  logic               out_valid_q, out_valid_d;
  logic               mode_q, mode_d;
  logic [SIZE_W-1:0]  size_q, size_d;
  logic [OFF_W-1:0]   off_q, off_d;
  logic [LVL_W-1:0]   need_q, need_d;
  logic [LVL_W-1:0]   lvl_q, lvl_d;
  logic [SUM_W-1:0]   idx_q, idx_d;
  logic [OFF_W-1:0]   res_off_q, res_off_d;
  logic               res_status_q, res_status_d;
  logic [OFF_W-1:0]   out_off_q, out_off_d;
  logic               out_status_q, out_status_d;

  logic               s_ready;
  logic [TOTAL_W-1:0] total;
  logic [LVL_W-1:0]   need_lvl;
  logic [OFF_W-1:0]   fpos;
  logic               free_ok;
  logic [SUM_W-1:0]   fidx;
  logic [POS_W-1:0]   blk_pos;

  // Level needed for the request: smallest block that holds size plus header
  always_comb begin
    total    = TOTAL_W'(size_q) + TOTAL_W'(HEADER_BYTES);
    need_lvl = FailLevel;
    for (int n = LEVEL_COUNT - 1; n >= 0; n--) begin
      if (CMP_W'(total) <= (CMP_W'(1) << (MIN_SHIFT + n))) begin
        need_lvl = LVL_W'(n);
      end
    end
  end

  // Check and convert the offset of a free request
  always_comb begin
    fpos    = off_q - OFF_W'(HEADER_BYTES);
    free_ok = (off_q >= OFF_W'(HEADER_BYTES)) && (fpos[MIN_SHIFT-1:0] == '0) &&
              (ACMP_W'(fpos) < ACMP_W'(ARENA_BYTES));
    fidx    = SUM_W'(fpos >> MIN_SHIFT);
  end

  // Byte offset of the current block plus header
  assign blk_pos = (POS_W'(idx_q) << MIN_SHIFT) + POS_W'(HEADER_BYTES);

  assign s_ready = (state_q == ST_IDLE) && init_done_i;

  // Next state, memory requests and result
  always_comb begin
    logic [SUM_W-1:0] nidx;
    logic [SUM_W-1:0] bidx;
    logic [LVL_W-1:0] nlvl;

    nidx = '0;
    bidx = '0;
    nlvl = '0;

    state_d      = state_q;
    mode_d       = mode_q;
    size_d       = size_q;
    off_d        = off_q;
    need_d       = need_q;
    lvl_d        = lvl_q;
    idx_d        = idx_q;
    res_off_d    = res_off_q;
    res_status_d = res_status_q;
    out_off_d    = out_off_q;
    out_status_d = out_status_q;
    out_valid_d  = out_valid_q & ~m_ready_i;

    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q[IDX_W-1:0];
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q[IDX_W-1:0];
    mem_wdata_o = '0;

    case (state_q)
      ST_IDLE: begin
        if (s_valid_i && s_ready) begin
          mode_d  = mode_i;
          size_d  = request_size_i;
          off_d   = free_offset_i;
          state_d = ST_DECODE;
        end
      end

      ST_DECODE: begin
        res_off_d    = '0;
        res_status_d = STATUS_OK;
        if (mode_q == MODE_ALLOC) begin
          if (need_lvl == FailLevel) begin
            res_status_d = STATUS_NO_SPACE;
            state_d      = ST_RESP;
          end else begin
            // start the walk at the first slot
            need_d      = need_lvl;
            idx_d       = '0;
            mem_re_o    = 1'b1;
            mem_raddr_o = '0;
            state_d     = ST_WALK;
          end
        end else if (free_ok) begin
          idx_d       = fidx;
          mem_re_o    = 1'b1;
          mem_raddr_o = fidx[IDX_W-1:0];
          state_d     = ST_FREE_HDR;
        end else begin
          state_d = ST_RESP;
        end
      end

      // One header per cycle: take it or step over its block
      ST_WALK: begin
        if ((mem_rdata_i.level >= need_q) && !mem_rdata_i.taken) begin
          lvl_d   = mem_rdata_i.level;
          state_d = ST_SPLIT;
        end else begin
          nidx = idx_q + (SUM_W'(1) << mem_rdata_i.level);
          if (nidx >= SUM_W'(SLOT_COUNT)) begin
            res_status_d = STATUS_NO_SPACE;
            state_d      = ST_RESP;
          end else begin
            idx_d       = nidx;
            mem_re_o    = 1'b1;
            mem_raddr_o = nidx[IDX_W-1:0];
          end
        end
      end

      // Halve the block, leave the lower half free and move into the upper one; at the needed level mark it taken
      ST_SPLIT: begin
        mem_we_o = idx_q < SUM_W'(SLOT_COUNT);
        if (lvl_q > need_q) begin
          nlvl        = lvl_q - 1'b1;
          mem_wdata_o = '{taken: 1'b0, level: nlvl};
          idx_d       = idx_q | (SUM_W'(1) << nlvl);
          lvl_d       = nlvl;
        end else begin
          mem_wdata_o  = '{taken: 1'b1, level: lvl_q};
          res_off_d    = blk_pos[OFF_W-1:0];
          res_status_d = STATUS_OK;
          state_d      = ST_RESP;
        end
      end

      // Release the block, then look at its buddy
      ST_FREE_HDR: begin
        lvl_d       = mem_rdata_i.level;
        mem_we_o    = 1'b1;
        mem_wdata_o = '{taken: 1'b0, level: mem_rdata_i.level};
        bidx        = idx_q ^ (SUM_W'(1) << mem_rdata_i.level);
        if ((mem_rdata_i.level < TopLevel) && (bidx < SUM_W'(SLOT_COUNT))) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = bidx[IDX_W-1:0];
          state_d     = ST_FREE_MERGE;
        end else begin
          state_d = ST_RESP;
        end
      end

      // Merge with a free buddy of equal level and climb one level
      ST_FREE_MERGE: begin
        if ((mem_rdata_i.level != lvl_q) || mem_rdata_i.taken) begin
          state_d = ST_RESP;
        end else begin
          nlvl        = lvl_q + 1'b1;
          nidx        = idx_q & ~((SUM_W'(2) << lvl_q) - SUM_W'(1));
          idx_d       = nidx;
          lvl_d       = nlvl;
          mem_we_o    = nidx < SUM_W'(SLOT_COUNT);
          mem_waddr_o = nidx[IDX_W-1:0];
          mem_wdata_o = '{taken: 1'b0, level: nlvl};
          bidx        = nidx ^ (SUM_W'(1) << nlvl);
          if ((nlvl < TopLevel) && (bidx < SUM_W'(SLOT_COUNT))) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = bidx[IDX_W-1:0];
          end else begin
            state_d = ST_RESP;
          end
        end
      end

      // Hand the result to the output register once it is free
      ST_RESP: begin
        if (!out_valid_q || m_ready_i) begin
          out_valid_d  = 1'b1;
          out_off_d    = res_off_q;
          out_status_d = res_status_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    size_q       <= size_d;
    off_q        <= off_d;
    need_q       <= need_d;
    lvl_q        <= lvl_d;
    idx_q        <= idx_d;
    res_off_q    <= res_off_d;
    res_status_q <= res_status_d;
    out_off_q    <= out_off_d;
    out_status_q <= out_status_d;
  end

  assign s_ready_o       = s_ready;
  assign m_valid_o       = out_valid_q;
  assign result_offset_o = out_off_q;
  assign status_o        = out_status_q;

endmodule

FILE: rtl/buddy_block_allocator_unit.sv
// Channel  | Beat fields (tdata low bit up)                  | tuser
// ---------+-------------------------------------------------+--------------
// s_axis   | request_size[12:0], free_offset[24:13], 0 pad   | mode
// m_axis   | result_offset[11:0], 0 pad                      | status
//
// Reset: a sweep writes all ARENA_BYTES >> MIN_SHIFT slot headers, one per cycle
// (128 by default), with s_axis_tready_o low meanwhile.
// One request at a time: allocate runs ST_DECODE, ST_WALK per header walked, ST_SPLIT
// per level split and to mark it taken, ST_RESP (no ST_SPLIT if nothing fits); free runs
// ST_DECODE, ST_FREE_HDR, ST_FREE_MERGE per buddy, ST_RESP; oversize/bad offset: ST_RESP.
// Stalls: a result waits in the output register; the next holds in ST_RESP until it goes.
module buddy_block_allocator_unit
  import bba_pkg::*;
#(
  parameter int unsigned ARENA_BYTES  = ArenaBytesDef,
  parameter int unsigned LEVEL_COUNT  = LevelCountDef,
  parameter int unsigned MIN_SHIFT    = MinShiftDef,
  parameter int unsigned HEADER_BYTES = HeaderBytesDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // request_size, free_offset
  input  logic                   s_axis_tuser_i,   // mode
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,   // result_offset
  output logic                   m_axis_tuser_o    // status
);

  localparam int unsigned SLOT_COUNT = ARENA_BYTES >> MIN_SHIFT;
  localparam int unsigned IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic             init_done;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  hdr_t             mem_rdata;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  hdr_t             mem_wdata;
  logic [OFF_W-1:0] result_offset;

  bba_hdr_ram #(
    .SLOT_COUNT  (SLOT_COUNT),
    .IDX_W       (IDX_W),
    .LEVEL_COUNT (LEVEL_COUNT)
  ) u_hdr_ram (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .re_i        (mem_re),
    .raddr_i     (mem_raddr),
    .rdata_o     (mem_rdata),
    .we_i        (mem_we),
    .waddr_i     (mem_waddr),
    .wdata_i     (mem_wdata),
    .init_done_o (init_done)
  );

  bba_ctrl #(
    .ARENA_BYTES  (ARENA_BYTES),
    .LEVEL_COUNT  (LEVEL_COUNT),
    .MIN_SHIFT    (MIN_SHIFT),
    .HEADER_BYTES (HEADER_BYTES),
    .SLOT_COUNT   (SLOT_COUNT),
    .IDX_W        (IDX_W)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .init_done_i     (init_done),
    .s_valid_i       (s_axis_tvalid_i),
    .s_ready_o       (s_axis_tready_o),
    .mode_i          (s_axis_tuser_i),
    .request_size_i  (s_axis_tdata_i[SIZE_W-1:0]),
    .free_offset_i   (s_axis_tdata_i[SIZE_W+OFF_W-1:SIZE_W]),
    .m_valid_o       (m_axis_tvalid_o),
    .m_ready_i       (m_axis_tready_i),
    .result_offset_o (result_offset),
    .status_o        (m_axis_tuser_o),
    .mem_re_o        (mem_re),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata)
  );

  assign m_axis_tdata_o = OUT_TDATA_W'(result_offset);

  // No beat is taken while the header memory is still being cleared
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_done |-> !s_axis_tready_o)
    else $error("request taken during clearing sweep");

  // A write never hits the slot being read in the same cycle
  a_rw_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_re && mem_we) |-> (mem_raddr != mem_waddr))
    else $error("header read and write collide");

  // A no-space result carries a zero offset
  a_nospace_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == STATUS_NO_SPACE)) |->
      (m_axis_tdata_o[OFF_W-1:0] == '0))
    else $error("no-space result with nonzero offset");

  // One request in flight: ready drops after an accepted beat
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("second request taken while busy");

endmodule

FILE: sim/tb_buddy_block_allocator_unit.sv
module tb_buddy_block_allocator_unit;
  import bba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOT_COUNT  = ArenaBytesDef >> MinShiftDef;
  localparam int unsigned TOP_LEVEL   = LevelCountDef - 1;
  localparam int unsigned RAND_ITEMS  = 650;
  localparam int unsigned TAIL_ITEMS  = 80;
  localparam int unsigned PAUSE_AT    = 300;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_WAIT  = 200;
  localparam int unsigned ROW_COUNT   = 24;

  // One reply beat as the block should produce it
  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic             status;
  } alloc_reply_t;

  // One directed beat; reply typed in only where it is obvious
  typedef struct packed {
    logic              mode;
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0]  offset;
    logic              typed;
    logic [OFF_W-1:0]  want_offset;
    logic              want_status;
  } req_row_t;

  localparam req_row_t DIRECTED_ROWS [ROW_COUNT] = '{
    // oversize requests, the size field all high on one of them
    '{MODE_ALLOC, 13'd4096, 12'hFFF, 1'b1, 12'd0, STATUS_NO_SPACE},
    '{MODE_ALLOC, 13'd8191, 12'd0,   1'b1, 12'd0, STATUS_NO_SPACE},
    '{MODE_ALLOC, 13'd4093, 12'd0,   1'b1, 12'd0, STATUS_NO_SPACE},
    // whole arena in one block, then nothing left
    '{MODE_ALLOC, 13'd4092, 12'd0,   1'b1, 12'd4,  STATUS_OK},
    '{MODE_ALLOC, 13'd0,    12'd0,   1'b1, 12'd0,  STATUS_NO_SPACE},
    '{MODE_FREE,  13'd8191, 12'd4,   1'b1, 12'd0,  STATUS_OK},
    // smallest block, exact fit at the minimum level, one byte over
    '{MODE_ALLOC, 13'd0,    12'd0,   1'b0, 12'd0,  STATUS_OK},
    '{MODE_ALLOC, 13'd28,   12'd0,   1'b0, 12'd0,  STATUS_OK},
    '{MODE_ALLOC, 13'd29,   12'd0,   1'b0, 12'd0,  STATUS_OK},
    '{MODE_ALLOC, 13'd2000, 12'd0,   1'b0, 12'd0,  STATUS_OK},
    // bad free offsets: below the header, misaligned, at the very top
    '{MODE_FREE,  13'd0,    12'd0,    1'b1, 12'd0, STATUS_OK},
    '{MODE_FREE,  13'd0,    12'd3,    1'b1, 12'd0, STATUS_OK},
    '{MODE_FREE,  13'd0,    12'd5,    1'b1, 12'd0, STATUS_OK},
    '{MODE_FREE,  13'd0,    12'd4095, 1'b1, 12'd0, STATUS_OK},
    // genuine frees, a double free and a free into a stale header
    '{MODE_FREE,  13'd0,    12'd4068, 1'b1, 12'd0, STATUS_OK},
    '{MODE_FREE,  13'd0,    12'd4068, 1'b1, 12'd0, STATUS_OK},
    '{MODE_FREE,  13'd0,    12'd2020, 1'b1, 12'd0, STATUS_OK},
    '{MODE_FREE,  13'd0,    12'd964,  1'b1, 12'd0, STATUS_OK},
    '{MODE_FREE,  13'd0,    12'd36,   1'b1, 12'd0, STATUS_OK},
    '{MODE_ALLOC, 13'd60,   12'd0,    1'b0, 12'd0, STATUS_OK},
    '{MODE_ALLOC, 13'd124,  12'd0,    1'b0, 12'd0, STATUS_OK},
    '{MODE_ALLOC, 13'd4092, 12'd0,    1'b0, 12'd0, STATUS_OK},
    '{MODE_FREE,  13'd0,    12'd4,    1'b1, 12'd0, STATUS_OK},
    '{MODE_ALLOC, 13'd4092, 12'd0,    1'b0, 12'd0, STATUS_OK}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   s_valid = 1'b0;
  logic                   s_mode  = 1'b0;
  logic [IN_TDATA_W-1:0]  s_data  = '0;
  logic                   m_ready = 1'b0;
  logic                   quiet_tail = 1'b0;
  logic                   s_axis_tready_o;
  logic                   m_axis_tvalid_o;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tuser_o;

  hdr_t                   arena_hdr [SLOT_COUNT];
  alloc_reply_t           pending_replies [$];
  logic [OFF_W-1:0]       live_offsets [$];
  int unsigned            fail_count = 0;
  int unsigned            stall_cycles = 0;
  int unsigned            ready_hold = 0;

  buddy_block_allocator_unit u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_mode),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Arena headers after reset: one free block spanning everything
  function automatic void clear_arena();
    foreach (arena_hdr[i]) begin
      arena_hdr[i] = '0;
    end
    arena_hdr[0].level = LVL_W'(TOP_LEVEL);
  endfunction

  // Header writes outside the arena are dropped
  function automatic void put_hdr(int unsigned pos, int unsigned lvl, logic taken);
    if ((pos >> MinShiftDef) < SLOT_COUNT) begin
      arena_hdr[pos >> MinShiftDef].level = LVL_W'(lvl);
      arena_hdr[pos >> MinShiftDef].taken = taken;
    end
  endfunction

  // First fit in address order, split keeping the upper half each time
  function automatic alloc_reply_t predict_alloc(logic [SIZE_W-1:0] size);
    alloc_reply_t reply;
    int unsigned  total;
    int unsigned  need;
    int unsigned  pos;
    int unsigned  lvl;
    bit           found;
    total = size + HeaderBytesDef;
    need  = 0;
    pos   = 0;
    found = 1'b0;
    reply = '{offset: '0, status: STATUS_NO_SPACE};
    while (need < LevelCountDef && total > (1 << (MinShiftDef + need)))
      need++;
    if (need > TOP_LEVEL)
      return reply;
    while (pos < ArenaBytesDef && !found) begin
      if (arena_hdr[pos >> MinShiftDef].level >= need && !arena_hdr[pos >> MinShiftDef].taken)
        found = 1'b1;
      else
        pos += 1 << (arena_hdr[pos >> MinShiftDef].level + MinShiftDef);
    end
    if (!found)
      return reply;
    lvl = arena_hdr[pos >> MinShiftDef].level;
    while (lvl > need) begin
      lvl--;
      put_hdr(pos, lvl, 1'b0);
      pos = pos | (1 << (lvl + MinShiftDef));
      put_hdr(pos, lvl, 1'b0);
    end
    put_hdr(pos, lvl, 1'b1);
    reply.offset = OFF_W'(pos + HeaderBytesDef);
    reply.status = STATUS_OK;
    return reply;
  endfunction

  // Release a block and fold it upward into free buddies of equal level
  function automatic void predict_free(logic [OFF_W-1:0] offset);
    int unsigned pos;
    int unsigned lvl;
    int unsigned bpos;
    if (offset < HeaderBytesDef)
      return;
    pos = offset - HeaderBytesDef;
    if ((pos & ((1 << MinShiftDef) - 1)) != 0 || pos >= ArenaBytesDef)
      return;
    lvl = arena_hdr[pos >> MinShiftDef].level;
    put_hdr(pos, lvl, 1'b0);
    while (lvl < TOP_LEVEL) begin
      bpos = pos ^ (1 << (lvl + MinShiftDef));
      if (bpos >= ArenaBytesDef)
        break;
      if (arena_hdr[bpos >> MinShiftDef].level != lvl || arena_hdr[bpos >> MinShiftDef].taken)
        break;
      pos &= ~((1 << (lvl + 1 + MinShiftDef)) - 1);
      lvl++;
      put_hdr(pos, lvl, 1'b0);
    end
    put_hdr(pos, lvl, 1'b0);
  endfunction

  // Present one request beat, hold it until taken, then log its reply
  task automatic send_request(input logic mode, input logic [SIZE_W-1:0] size,
                              input logic [OFF_W-1:0] offset, input logic typed,
                              input alloc_reply_t typed_reply);
    alloc_reply_t reply;
    bit           hit;
    s_valid <= 1'b1;
    s_mode  <= mode;
    s_data  <= {{(IN_TDATA_W - OFF_W - SIZE_W){1'b0}}, offset, size};
    do
      @(posedge clk);
    while (!s_axis_tready_o);
    if (mode == MODE_ALLOC) begin
      reply = predict_alloc(size);
      if (reply.status == STATUS_OK)
        live_offsets.push_back(reply.offset);
    end else begin
      predict_free(offset);
      reply = '{offset: '0, status: STATUS_OK};
      hit = 1'b0;
      for (int i = 0; i < live_offsets.size() && !hit; i++) begin
        if (live_offsets[i] == offset) begin
          live_offsets.delete(i);
          hit = 1'b1;
        end
      end
    end
    pending_replies.push_back(typed ? typed_reply : reply);
  endtask

  // Result side: random bursts of back-pressure, none in the tail
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      m_ready    <= 1'b0;
      ready_hold <= $urandom_range(0, 7);
    end else begin
      m_ready <= 1'b1;
    end
  end

  // Compare every reply beat with the oldest pending one
  always @(posedge clk) begin
    alloc_reply_t want;
    if (rst_n && m_axis_tvalid_o && m_ready) begin
      if (pending_replies.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected reply beat: offset %0d status %0b",
                   m_axis_tdata_o, m_axis_tuser_o);
      end else begin
        want = pending_replies.pop_front();
        if (m_axis_tdata_o !== {{(OUT_TDATA_W - OFF_W){1'b0}}, want.offset} ||
            m_axis_tuser_o !== want.status) begin
          fail_count++;
          if (fail_count <= 10)
            $display("reply mismatch: expected offset %0d status %0b, got offset %0d status %0b",
                     want.offset, want.status, m_axis_tdata_o, m_axis_tuser_o);
        end
      end
    end
  end

  // Count cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic              mode;
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0]  offset;
    int unsigned       pick;
    int unsigned       size_pick;
    alloc_reply_t      no_reply;
    no_reply = '0;
    rst_n = 1'b0;
    clear_arena();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows
    foreach (DIRECTED_ROWS[r]) begin
      send_request(DIRECTED_ROWS[r].mode, DIRECTED_ROWS[r].size, DIRECTED_ROWS[r].offset,
                   DIRECTED_ROWS[r].typed,
                   '{offset: DIRECTED_ROWS[r].want_offset,
                     status: DIRECTED_ROWS[r].want_status});
    end

    // Random churn: mostly allocs and frees of live blocks, some raw noise
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS - TAIL_ITEMS)
        quiet_tail <= 1'b1;
      pick   = $urandom_range(0, 99);
      mode   = MODE_ALLOC;
      size   = SIZE_W'($urandom_range(0, 8191));
      offset = OFF_W'($urandom_range(0, 4095));
      if (pick < 8) begin
        mode = ($urandom_range(0, 1) == 0) ? MODE_ALLOC : MODE_FREE;
      end else if (live_offsets.size() > 0 && (pick < 45 || live_offsets.size() > 48)) begin
        mode   = MODE_FREE;
        offset = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
      end else begin
        size_pick = $urandom_range(0, 19);
        if (size_pick < 12)
          size = SIZE_W'($urandom_range(0, 60));
        else if (size_pick < 17)
          size = SIZE_W'($urandom_range(61, 508));
        else if (size_pick < 19)
          size = SIZE_W'($urandom_range(509, 2044));
        else
          size = SIZE_W'($urandom_range(2045, 4092));
      end
      // Hold off once until the block has drained, otherwise idle in bursts
      if (n == PAUSE_AT) begin
        s_valid <= 1'b0;
        while (pending_replies.size() != 0)
          @(posedge clk);
      end else if (n > 0 && n < RAND_ITEMS - TAIL_ITEMS && $urandom_range(0, 3) == 0) begin
        s_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      send_request(mode, size, offset, 1'b0, no_reply);
    end

    // Drain and watch for stray beats
    s_valid <= 1'b0;
    while (pending_replies.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && pending_replies.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bba_pkg.sv
rtl/bba_hdr_ram.sv
rtl/bba_ctrl.sv
rtl/buddy_block_allocator_unit.sv
sim/tb_buddy_block_allocator_unit.sv
